[src/wpp_pkg.sv]
package wpp_pkg;

	localparam int unsigned RES_DEPTH = 8;
	localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
	localparam int unsigned RES_CNT_W = RES_PTR_W + 1;

	// Four-character codes as they sit in the file, first byte in the low lane
	localparam logic [31:0] HDR_RIFF = 32'h4646_4952;
	localparam logic [31:0] HDR_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [15:0] FMT_PCM      = 16'd1;
	localparam logic [15:0] BITS_16      = 16'd16;
	localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
	localparam logic [32:0] HDR_LEN      = 33'd12;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_CHUNK,
		PH_FMT,
		PH_SKIP,
		PH_DATA,
		PH_END
	} phase_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE,
		KIND_DONE,
		KIND_ERROR
	} kind_t;

	typedef enum logic [3:0] {
		ERR_BAD_HEADER,
		ERR_FMT_SMALL,
		ERR_FMT_TRUNC,
		ERR_DATA_BEFORE_FMT,
		ERR_NOT_PCM,
		ERR_NOT_16BIT,
		ERR_NO_CHANNELS,
		ERR_DATA_TRUNC,
		ERR_NO_DATA
	} err_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [15:0] sample;
		logic [31:0]        rate_hz;
		err_t               error_code;
		logic               last;
	} result_t;

	// Up to two results per byte: a sample followed by the done result
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} step_t;

	function automatic result_t err_res(err_t e);
		result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.error_code = e;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic result_t done_res(logic [31:0] rate);
		result_t r;
		r = '0;
		r.kind = KIND_DONE;
		r.rate_hz = rate;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic result_t smp_res(logic [15:0] s);
		result_t r;
		r = '0;
		r.kind = KIND_SAMPLE;
		r.sample = s;
		return r;
	endfunction

endpackage

[src/wpp_byte_if.sv]
interface wpp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_file;

	modport source(output valid, data_byte, end_of_file, input ready);
	modport sink(input valid, data_byte, end_of_file, output ready);
endinterface

[src/wpp_res_if.sv]
interface wpp_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [15:0] sample;
	logic [31:0]        rate_hz;
	logic [3:0]         error_code;
	logic               last;

	modport source(output valid, kind, sample, rate_hz, error_code, last, input ready);
	modport sink(input valid, kind, sample, rate_hz, error_code, last, output ready);
endinterface

[src/wpp_core.sv]
module wpp_core
	import wpp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	input  logic [7:0] data_byte,
	input  logic       end_of_file,
	output step_t      step
);

	phase_t      phase_q, phase_d;
	logic [32:0] cnt_q, cnt_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] len_q, len_d;
	logic [15:0] fmt_q, fmt_d;
	logic [15:0] ch_q, ch_d;
	logic [15:0] bits_q, bits_d;
	logic [31:0] rate_q, rate_d;
	logic        have_fmt_q, have_fmt_d;
	logic [16:0] fpos_q, fpos_d;
	logic [31:0] rem_q, rem_d;
	logic [7:0]  low_q, low_d;
	logic        hdr_ok_q, hdr_ok_d;

	logic [32:0] cnt_inc, cnt_dec;
	logic [16:0] fpos_inc, frame_bytes;
	logic [31:0] rem_dec;
	logic [3:0]  hidx;
	logic [2:0]  cidx;

	assign cnt_inc     = cnt_q + 33'd1;
	assign cnt_dec     = cnt_q - 33'd1;
	assign fpos_inc    = fpos_q + 17'd1;
	assign rem_dec     = rem_q - 32'd1;
	assign frame_bytes = {ch_q, 1'b0};
	assign hidx        = cnt_q[3:0];
	assign cidx        = cnt_q[2:0];

	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		tag_d      = tag_q;
		len_d      = len_q;
		fmt_d      = fmt_q;
		ch_d       = ch_q;
		bits_d     = bits_q;
		rate_d     = rate_q;
		have_fmt_d = have_fmt_q;
		fpos_d     = fpos_q;
		rem_d      = rem_q;
		low_d      = low_q;
		hdr_ok_d   = hdr_ok_q;
		step       = '0;

		if (valid && end_of_file) begin
			case (phase_q)
				PH_HEADER: begin
					step.count = 2'd1;
					step.first = err_res(ERR_BAD_HEADER);
				end
				PH_CHUNK, PH_SKIP: begin
					step.count = 2'd1;
					step.first = err_res(ERR_NO_DATA);
				end
				PH_FMT: begin
					step.count = 2'd1;
					step.first = err_res(ERR_FMT_TRUNC);
				end
				PH_DATA: begin
					step.count = 2'd1;
					step.first = err_res(ERR_DATA_TRUNC);
				end
				default: ;
			endcase
			phase_d    = PH_HEADER;
			cnt_d      = '0;
			tag_d      = '0;
			len_d      = '0;
			fmt_d      = '0;
			ch_d       = '0;
			bits_d     = '0;
			rate_d     = '0;
			have_fmt_d = 1'b0;
			fpos_d     = '0;
			rem_d      = '0;
			low_d      = '0;
			hdr_ok_d   = 1'b1;
		end else if (valid) begin
			case (phase_q)
				PH_HEADER: begin
					if (hidx < 4'd4 && data_byte != HDR_RIFF[8*hidx[1:0] +: 8])
						hdr_ok_d = 1'b0;
					if (hidx >= 4'd8 && hidx < 4'd12 &&
						data_byte != HDR_WAVE[8*hidx[1:0] +: 8])
						hdr_ok_d = 1'b0;
					cnt_d = cnt_inc;
					if (cnt_inc >= HDR_LEN) begin
						cnt_d = '0;
						if (!hdr_ok_d) begin
							step.count = 2'd1;
							step.first = err_res(ERR_BAD_HEADER);
							phase_d = PH_END;
						end else begin
							phase_d = PH_CHUNK;
						end
					end
				end
				PH_CHUNK: begin
					if (!cidx[2]) begin
						if (cidx == 3'd0)
							tag_d = '0;
						tag_d[8*cidx[1:0] +: 8] = data_byte;
					end else begin
						if (cidx == 3'd4)
							len_d = '0;
						len_d[8*cidx[1:0] +: 8] = data_byte;
					end
					cnt_d = cnt_inc;
					if (cidx == 3'd7) begin
						cnt_d = '0;
						if (tag_q == TAG_FMT) begin
							if (len_d < FMT_MIN_LEN) begin
								step.count = 2'd1;
								step.first = err_res(ERR_FMT_SMALL);
								phase_d = PH_END;
							end else begin
								phase_d = PH_FMT;
							end
						end else if (tag_q == TAG_DATA) begin
							step.count = 2'd1;
							phase_d = PH_END;
							if (!have_fmt_q)
								step.first = err_res(ERR_DATA_BEFORE_FMT);
							else if (fmt_q != FMT_PCM)
								step.first = err_res(ERR_NOT_PCM);
							else if (bits_q != BITS_16)
								step.first = err_res(ERR_NOT_16BIT);
							else if (ch_q == '0)
								step.first = err_res(ERR_NO_CHANNELS);
							else begin
								rem_d = len_d;
								fpos_d = '0;
								if (len_d < {15'd0, frame_bytes}) begin
									step.first = done_res(rate_q);
								end else begin
									step.count = 2'd0;
									phase_d = PH_DATA;
								end
							end
						end else begin
							// unknown chunk: skip body plus pad byte
							cnt_d = {1'b0, len_d} + {32'd0, len_d[0]};
							phase_d = (len_d == '0) ? PH_CHUNK : PH_SKIP;
						end
					end
				end
				PH_FMT: begin
					if (cnt_q[32:4] == '0) begin
						case (cnt_q[3:0])
							4'd0:  fmt_d = {8'd0, data_byte};
							4'd1:  fmt_d[15:8] = data_byte;
							4'd2:  ch_d = {8'd0, data_byte};
							4'd3:  ch_d[15:8] = data_byte;
							4'd4:  rate_d = {24'd0, data_byte};
							4'd5:  rate_d[15:8] = data_byte;
							4'd6:  rate_d[23:16] = data_byte;
							4'd7:  rate_d[31:24] = data_byte;
							4'd14: bits_d = {8'd0, data_byte};
							4'd15: bits_d[15:8] = data_byte;
							default: ;
						endcase
					end
					cnt_d = cnt_inc;
					if (cnt_inc >= {1'b0, len_q}) begin
						have_fmt_d = 1'b1;
						cnt_d = '0;
						phase_d = PH_CHUNK;
					end
				end
				PH_SKIP: begin
					cnt_d = cnt_dec;
					if (cnt_dec == '0)
						phase_d = PH_CHUNK;
				end
				PH_DATA: begin
					if (fpos_q == '0) begin
						low_d = data_byte;
					end else if (fpos_q == 17'd1) begin
						step.count = 2'd1;
						step.first = smp_res({data_byte, low_q});
					end
					rem_d = rem_dec;
					fpos_d = fpos_inc;
					if (fpos_inc >= frame_bytes) begin
						fpos_d = '0;
						if (rem_dec < {15'd0, frame_bytes}) begin
							phase_d = PH_END;
							if (step.count == 2'd1) begin
								step.count = 2'd2;
								step.second = done_res(rate_q);
							end else begin
								step.count = 2'd1;
								step.first = done_res(rate_q);
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			cnt_q      <= '0;
			tag_q      <= '0;
			len_q      <= '0;
			fmt_q      <= '0;
			ch_q       <= '0;
			bits_q     <= '0;
			rate_q     <= '0;
			have_fmt_q <= 1'b0;
			fpos_q     <= '0;
			rem_q      <= '0;
			low_q      <= '0;
			hdr_ok_q   <= 1'b1;
		end else begin
			phase_q    <= phase_d;
			cnt_q      <= cnt_d;
			tag_q      <= tag_d;
			len_q      <= len_d;
			fmt_q      <= fmt_d;
			ch_q       <= ch_d;
			bits_q     <= bits_d;
			rate_q     <= rate_d;
			have_fmt_q <= have_fmt_d;
			fpos_q     <= fpos_d;
			rem_q      <= rem_d;
			low_q      <= low_d;
			hdr_ok_q   <= hdr_ok_d;
		end
	end

endmodule

[src/wav_pcm16_stream_parser_top.sv]
// A byte is first captured in the input register; the core's results for it are then
// written into the result queue, from which the earliest one is offered and transferred.
// Throughput: one byte per cycle; the input stalls only while the 8-entry result queue
// cannot hold two results for the byte in the input register plus two for a new byte.
// Reset: arst_n clears the parser state, the input stage and the result queue.
// An end-of-file item also returns the parser to its reset state.
module wav_pcm16_stream_parser_top
	import wpp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	wpp_byte_if.sink bytes,
	wpp_res_if.source results
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	step_t      core_step;

	result_t                res_mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0]   wr_q, rd_q;
	logic [RES_CNT_W-1:0]   count_q;
	logic [RES_CNT_W:0]     load;
	logic                   pop;
	result_t                head;

	assign load = {1'b0, count_q} + {{(RES_CNT_W-1){1'b0}}, valid_s1, 1'b0};
	assign bytes.ready = (load <= (RES_CNT_W+1)'(RES_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= bytes.valid && bytes.ready;
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.data_byte;
			eof_s1  <= bytes.end_of_file;
		end
	end

	wpp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid       (valid_s1),
		.data_byte   (byte_s1),
		.end_of_file (eof_s1),
		.step        (core_step)
	);

	assign pop  = results.valid && results.ready;
	assign head = res_mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (core_step.count != 2'd0)
			res_mem_q[wr_q] <= core_step.first;
		if (core_step.count == 2'd2)
			res_mem_q[wr_q + RES_PTR_W'(1)] <= core_step.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + RES_PTR_W'(core_step.count);
			rd_q    <= rd_q + RES_PTR_W'(pop);
			count_q <= count_q + RES_CNT_W'(core_step.count) - RES_CNT_W'(pop);
		end
	end

	assign results.valid      = (count_q != '0);
	assign results.kind       = head.kind;
	assign results.sample     = head.sample;
	assign results.rate_hz    = head.rate_hz;
	assign results.error_code = head.error_code;
	assign results.last       = head.last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= RES_CNT_W'(RES_DEPTH))
		else $error("result queue overflow");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		core_step.count == 2'd2 |->
			core_step.first.kind == KIND_SAMPLE && core_step.second.kind == KIND_DONE)
		else $error("two results from one byte must be sample then done");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> ((results.kind == KIND_SAMPLE) != results.last))
		else $error("last flag disagrees with result kind");

endmodule
